FILE: rtl/core/tva_pkg.sv
// tva_pkg: item types, state codes and the nice-to-weight table
// for the vruntime accounting block
// no dependencies
package tva_pkg;

  // input item
  typedef struct packed {
    logic [63:0] timestamp;
    logic [2:0]  next_state;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0]  previous_state;
    logic [63:0] real_runtime;
    logic [63:0] virtual_runtime;
  } out_item_t;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  localparam logic [2:0] TASK_NEWBORN = 3'd0;
  localparam logic [2:0] TASK_RUNNING = 3'd1;

  localparam int WEIGHT_W   = 17;
  localparam int SCALE_BITS = 10;   // elapsed time times 1024
  localparam int DIV_STEPS  = 64 + SCALE_BITS;
  localparam int NICE_COUNT = 40;

  localparam logic signed [7:0] NICE_MIN = -8'sd20;
  localparam logic signed [7:0] NICE_MAX = 8'sd19;

  localparam logic [WEIGHT_W-1:0] WEIGHT_TABLE [NICE_COUNT] = '{
    17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291,
    17'd29154, 17'd23254, 17'd18705, 17'd14949, 17'd11916,
    17'd9548,  17'd7620,  17'd6100,  17'd4904,  17'd3906,
    17'd3121,  17'd2501,  17'd1991,  17'd1586,  17'd1277,
    17'd1024,  17'd820,   17'd655,   17'd526,   17'd423,
    17'd335,   17'd272,   17'd215,   17'd172,   17'd137,
    17'd110,   17'd87,    17'd70,    17'd56,    17'd45,
    17'd36,    17'd29,    17'd23,    17'd18,    17'd15
  };

  // clamp the nice level and look up its weight
  function automatic logic [WEIGHT_W-1:0] weight_of_nice(input logic signed [7:0] nice);
    logic signed [7:0] n;
    logic [5:0]        idx;
    n = nice;
    if (n < NICE_MIN) n = NICE_MIN;
    if (n > NICE_MAX) n = NICE_MAX;
    idx = 6'(n - NICE_MIN);
    return WEIGHT_TABLE[idx];
  endfunction

endpackage

FILE: rtl/core/task_vruntime_accounting.sv
// task_vruntime_accounting: per-task runtime and weighted vruntime accounting
// depends on tva_pkg and tva_div
//
// channel   direction  handshake                 payload
// in_       input      in_valid / in_ready       tva_pkg::in_item_t (timestamp, next_state)
// out_      output     out_valid / out_ready     tva_pkg::out_item_t (previous_state, totals)
// apb       input      psel/penable/pwrite       nice_level at address 0, pready always high
//
// an item leaving a running task goes through accept, 74 divider steps plus
// the divider done strobe, accumulate, and the result write
// an item from any other state goes through accept and the result write
// in_ready is high only while the sequencer idles; a result left in the output
// register does not hold off the next item, only the next result write
// reset (synchronous, active low) clears state code, timestamp, totals and nice level
module task_vruntime_accounting (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tva_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tva_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic REG_NICE = 1'b0;

  logic [1:0]                   state_r, state_nxt;
  logic [2:0]                   cur_state_r, cur_state_nxt;
  logic [2:0]                   prev_r, prev_nxt;
  logic [63:0]                  phase_r, phase_nxt;
  logic [63:0]                  runtime_r, runtime_nxt;
  logic [63:0]                  vruntime_r, vruntime_nxt;
  logic [63:0]                  delta_r, delta_nxt;
  logic [7:0]                   nice_r, nice_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tva_pkg::out_item_t           out_data_r, out_data_nxt;
  logic [63:0]                  delta;
  logic [tva_pkg::WEIGHT_W-1:0] weight;
  logic                         accept;
  logic                         was_running;
  logic                         cfg_wr;
  logic                         out_free;
  tva_pkg::div_ctl_t            div_ctl;
  tva_pkg::div_sts_t            div_sts;
  logic [63:0]                  quotient;

  assign accept      = in_valid && in_ready;
  assign in_ready    = (state_r == ST_IDLE);
  assign was_running = (cur_state_r == tva_pkg::TASK_RUNNING);
  assign delta       = in_data.timestamp - phase_r;
  assign weight      = tva_pkg::weight_of_nice(signed'(nice_r));
  assign out_free    = !out_valid_r || out_ready;

  // divider starts on an item that ends a running phase
  assign div_ctl.start = accept && was_running;

  tva_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (delta),
    .divisor  (weight),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // config register
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign nice_nxt = (cfg_wr && paddr[2] == REG_NICE) ? pwdata[7:0] : nice_r;
  assign prdata   = (paddr[2] == REG_NICE) ? {24'd0, nice_r} : 32'd0;
  assign pready   = 1'b1;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_state_nxt = cur_state_r;
    prev_nxt      = prev_r;
    phase_nxt     = phase_r;
    runtime_nxt   = runtime_r;
    vruntime_nxt  = vruntime_r;
    delta_nxt     = delta_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          prev_nxt      = cur_state_r;
          cur_state_nxt = in_data.next_state;
          phase_nxt     = in_data.timestamp;
          delta_nxt     = delta;
          state_nxt     = was_running ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        runtime_nxt  = runtime_r + delta_r;
        vruntime_nxt = vruntime_r + quotient;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.previous_state = prev_r;
          out_data_nxt.real_runtime   = runtime_r;
          out_data_nxt.virtual_runtime = vruntime_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_state_r <= tva_pkg::TASK_NEWBORN;
      phase_r     <= '0;
      runtime_r   <= '0;
      vruntime_r  <= '0;
      nice_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_state_r <= cur_state_nxt;
      phase_r     <= phase_nxt;
      runtime_r   <= runtime_nxt;
      vruntime_r  <= vruntime_nxt;
      nice_r      <= nice_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    delta_r    <= delta_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // leaving a running phase goes through the divider
  a_run_divides: assert property (@(posedge clk) disable iff (!rst_n)
    accept && was_running |=> state_r == ST_DIV && div_sts.busy)
    else $error("running item did not start the divider");

  // totals hold for an item that ends a non-running phase
  a_idle_totals: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !was_running |=> $stable(runtime_r) && $stable(vruntime_r))
    else $error("totals changed outside a running phase");

  // divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV)
    else $error("divider done outside divide state");

  // a result write always returns the sequencer to idle with a valid item
  a_fin_writes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("result write missed");

endmodule

FILE: rtl/core/tva_div.sv
// tva_div: restoring bit-serial divider, one quotient bit per cycle
// divides (dividend * 1024) by a 17-bit weight, keeps the low 64 quotient bits
// depends on tva_pkg
module tva_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tva_pkg::div_ctl_t             ctl,
  input  logic [63:0]                   dividend,
  input  logic [tva_pkg::WEIGHT_W-1:0]  divisor,
  output tva_pkg::div_sts_t             sts,
  output logic [63:0]                   quotient
);

  localparam int CNT_W = $clog2(tva_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tva_pkg::DIV_STEPS - 1);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [63:0]                  dvd_r, dvd_nxt;
  logic [63:0]                  quo_r, quo_nxt;
  logic [tva_pkg::WEIGHT_W-1:0] rem_r, rem_nxt;
  logic [tva_pkg::WEIGHT_W-1:0] div_r, div_nxt;
  logic [tva_pkg::WEIGHT_W:0]   trial;
  logic                         fits;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem_r, dvd_r[63]};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // after the 64 timestamp bits, zeros feed in for the scale factor
      dvd_nxt = {dvd_r[62:0], 1'b0};
      quo_nxt = {quo_r[62:0], fits};
      rem_nxt = fits ? tva_pkg::WEIGHT_W'(trial - {1'b0, div_r})
                     : tva_pkg::WEIGHT_W'(trial);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

  // remainder always stays below the divisor while stepping
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < div_r)
    else $error("divider remainder not below divisor");

  // done follows the last step only
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && $past(cnt_r) == LAST_STEP)
    else $error("divider done without last step");

endmodule

FILE: bench/task_vruntime_accounting_tb.sv
// task_vruntime_accounting_tb: self-checking bench for the vruntime accounting block
// directed table then random state changes, each result checked against its table row or a local predictor
// depends on tva_pkg and task_vruntime_accounting
`timescale 1ns / 1ps

module task_vruntime_accounting_tb;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 10;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 118;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 100;
  localparam int TIMEOUT_CYCLES  = 600000;
  localparam int MAX_REPORTS     = 10;

  localparam logic [2:0] NICE_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  localparam logic [63:0] STAMP_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // weights by clamped nice level, -20 first
  localparam int unsigned NICE_WEIGHTS [40] = '{
    88761, 71755, 56483, 46273, 36291, 29154, 23254, 18705, 14949, 11916,
    9548,  7620,  6100,  4904,  3906,  3121,  2501,  1991,  1586,  1277,
    1024,  820,   655,   526,   423,   335,   272,   215,   172,   137,
    110,   87,    70,    56,    45,    36,    29,    23,    18,    15
  };

  typedef enum logic {ROW_CHANGE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [2:0]          addr;
    logic [31:0]         wdata;
    tva_pkg::in_item_t   change;
    bit                  typed;
    tva_pkg::out_item_t  totals;
  } dir_row_t;

  // dut signals
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  tva_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  tva_pkg::out_item_t out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor copy of the task state
  logic [7:0]  nice_reg;
  logic [2:0]  task_state;
  logic [63:0] last_stamp;
  logic [63:0] run_sum;
  logic [63:0] vrun_sum;

  tva_pkg::out_item_t pending_totals [$];
  dir_row_t           dir_rows [$];
  int                 mismatch_count = 0;
  int                 idle_pct = 25;
  logic [63:0]        stamp_cursor = '0;

  // receiver hold-off control
  logic        hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;

  task_vruntime_accounting uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // weight of the clamped nice level
  function automatic int unsigned nice_weight(logic signed [7:0] nice);
    int n;
    n = nice;
    if (n < -20) n = -20;
    if (n > 19) n = 19;
    return NICE_WEIGHTS[n + 20];
  endfunction

  // apply one state change to the predictor, return the totals it should report
  function automatic tva_pkg::out_item_t account_change(tva_pkg::in_item_t chg);
    tva_pkg::out_item_t res;
    logic [63:0]        delta;
    logic [79:0]        scaled;
    logic [79:0]        quot;
    res.previous_state = task_state;
    if (task_state == tva_pkg::TASK_RUNNING) begin
      delta    = chg.timestamp - last_stamp;
      scaled   = {16'd0, delta} << 10;
      quot     = scaled / 80'(nice_weight(nice_reg));
      run_sum  = run_sum + delta;
      vrun_sum = vrun_sum + quot[63:0];
    end
    last_stamp = chg.timestamp;
    task_state = chg.next_state;
    res.real_runtime    = run_sum;
    res.virtual_runtime = vrun_sum;
    return res;
  endfunction

  // random change: mostly advancing timestamps, some noise
  function automatic tva_pkg::in_item_t next_random_change();
    tva_pkg::in_item_t chg;
    logic [63:0]       step;
    int                pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4, 5: step = 64'($urandom_range(0, 100000));
      6, 7:             step = 64'($urandom);
      8:                step = {$urandom, $urandom};
      default:          step = '0;
    endcase
    if ($urandom_range(0, 99) < 85) begin
      stamp_cursor = stamp_cursor + step;
    end else begin
      stamp_cursor = {$urandom, $urandom};
    end
    chg.timestamp = stamp_cursor;
    if ($urandom_range(0, 99) < 60) begin
      chg.next_state = tva_pkg::TASK_RUNNING;
    end else begin
      chg.next_state = 3'($urandom_range(0, 7));
    end
    return chg;
  endfunction

  function automatic void change_row(logic [63:0] ts, logic [2:0] nxt, bit typed,
                                     logic [2:0] prev, logic [63:0] rt, logic [63:0] vt);
    dir_row_t r;
    r.kind   = ROW_CHANGE;
    r.addr   = '0;
    r.wdata  = '0;
    r.change = '{timestamp: ts, next_state: nxt};
    r.typed  = typed;
    r.totals = '{previous_state: prev, real_runtime: rt, virtual_runtime: vt};
    dir_rows.push_back(r);
  endfunction

  function automatic void write_row(logic [2:0] addr, logic [31:0] data);
    dir_row_t r;
    r.kind   = ROW_WRITE;
    r.addr   = addr;
    r.wdata  = data;
    r.change = '0;
    r.typed  = 1'b0;
    r.totals = '0;
    dir_rows.push_back(r);
  endfunction

  // offer one item, return at the edge it is accepted
  task automatic send_change(tva_pkg::in_item_t chg, bit typed,
                             tva_pkg::out_item_t typed_totals);
    tva_pkg::out_item_t predicted;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= chg;
    do @(posedge clk); while (!in_ready);
    predicted = account_change(chg);
    pending_totals.push_back(typed ? typed_totals : predicted);
  endtask

  // register write once the block has emptied
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    in_valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == NICE_ADDR) nice_reg = data[7:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // let the bus idle before anything else is driven
    @(posedge clk);
  endtask

  // receiver: random stall bursts and one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
      stall_left <= $urandom_range(1, 14) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    tva_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_totals.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: prev %0d rt %h vt %h",
                   out_data.previous_state, out_data.real_runtime, out_data.virtual_runtime);
      end else begin
        want = pending_totals.pop_front();
        if (out_data.previous_state !== want.previous_state ||
            out_data.real_runtime !== want.real_runtime ||
            out_data.virtual_runtime !== want.virtual_runtime) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected prev %0d rt %h vt %h, got prev %0d rt %h vt %h",
                     want.previous_state, want.real_runtime, want.virtual_runtime,
                     out_data.previous_state, out_data.real_runtime,
                     out_data.virtual_runtime);
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t          row;
    tva_pkg::in_item_t chg;
    logic [31:0]       wd;
    logic [7:0]        nice_pick;

    nice_reg   = '0;
    task_state = tva_pkg::TASK_NEWBORN;
    last_stamp = '0;
    run_sum    = '0;
    vrun_sum   = '0;

    // directed table: reset values, wraps, clamps, truncation, ignored address
    change_row(64'd100, tva_pkg::TASK_RUNNING, 1, tva_pkg::TASK_NEWBORN, 64'd0, 64'd0);
    change_row(64'd1124, tva_pkg::TASK_RUNNING, 1, tva_pkg::TASK_RUNNING, 64'd1024, 64'd1024);
    change_row(64'd2148, 3'd2, 1, tva_pkg::TASK_RUNNING, 64'd2048, 64'd2048);
    change_row(64'd0, 3'd3, 1, 3'd2, 64'd2048, 64'd2048);
    change_row(STAMP_MAX, tva_pkg::TASK_RUNNING, 1, 3'd3, 64'd2048, 64'd2048);
    change_row(64'd5, 3'd4, 1, tva_pkg::TASK_RUNNING, 64'd2054, 64'd2054);
    write_row(NICE_ADDR, 32'h0000_0080);
    change_row(64'd6, tva_pkg::TASK_RUNNING, 1, 3'd4, 64'd2054, 64'd2054);
    change_row(64'd5, 3'd5, 0, '0, '0, '0);
    write_row(NICE_ADDR, 32'h0000_007F);
    change_row(64'd0, tva_pkg::TASK_RUNNING, 0, '0, '0, '0);
    change_row(STAMP_MAX, 3'd6, 0, '0, '0, '0);
    write_row(NICE_ADDR, 32'h0000_00EC);
    change_row(64'd0, tva_pkg::TASK_RUNNING, 0, '0, '0, '0);
    change_row(64'd1000000, 3'd7, 0, '0, '0, '0);
    write_row(NICE_ADDR, 32'h0000_0013);
    change_row(64'd0, tva_pkg::TASK_RUNNING, 0, '0, '0, '0);
    change_row(64'd1500, tva_pkg::TASK_RUNNING, 0, '0, '0, '0);
    write_row(SPARE_ADDR, 32'h0000_0000);
    change_row(64'd3000, tva_pkg::TASK_RUNNING, 0, '0, '0, '0);
    write_row(NICE_ADDR, 32'hABCD_EF14);
    change_row(64'h8000_0000_0000_0000, tva_pkg::TASK_NEWBORN, 0, '0, '0, '0);
    change_row(64'h8000_0000_0001_0000, tva_pkg::TASK_RUNNING, 0, '0, '0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_WRITE) begin
        apb_write(row.addr, row.wdata);
      end else begin
        send_change(row.change, row.typed, row.totals);
      end
    end
    stamp_cursor = last_stamp;

    // random phases, each under its own nice level
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       nice_pick = 8'h80;
        1:       nice_pick = 8'h7F;
        2:       nice_pick = 8'hEC;
        3:       nice_pick = 8'h13;
        4:       nice_pick = 8'h00;
        default: nice_pick = 8'($urandom);
      endcase
      wd = $urandom;
      wd[7:0] = nice_pick;
      apb_write(NICE_ADDR, wd);
      if (ph == 5) apb_write(SPARE_ADDR, $urandom);
      idle_pct <= (ph == 3 || ph == PHASES - 1) ? 0 : 25;
      if (ph == 1) hold_req <= 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        chg = next_random_change();
        send_change(chg, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // drain, then let the block settle
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_totals.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tva_pkg.sv
rtl/core/tva_div.sv
rtl/core/task_vruntime_accounting.sv
bench/task_vruntime_accounting_tb.sv
